[design/ust_pkg.sv]
// Shared types, constants and helper functions for the upload slice tracker.
// Used by ust_bitmap and upload_slice_tracker_core; depends on nothing else.
`default_nettype none

package ust_pkg;

  localparam int SLICE_SHIFT = 20;
  localparam int SLICE_BYTES = 1 << SLICE_SHIFT;
  localparam int MAX_SLICES  = 1024;

  localparam int FSIZE_W = 31;
  localparam int SLICE_W = 11;
  localparam int LEN_W   = 21;

  // The completion bitmap is held as rows of ROW_BITS flags.
  localparam int ROW_BITS = 32;
  localparam int ROWS     = MAX_SLICES / ROW_BITS;
  localparam int ROW_W    = $clog2(ROWS);
  localparam int BIT_W    = $clog2(ROW_BITS);
  localparam int IDX_W    = ROW_W + BIT_W;

  typedef logic [ROW_BITS-1:0] row_t;

  typedef struct packed {
    logic             clear;
    logic             rd_en;
    logic [ROW_W-1:0] rd_row;
    logic             wr_en;
    logic [ROW_W-1:0] wr_row;
    row_t             wr_data;
  } bm_req_t;

  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] idx;
  } fz_t;

  // Lowest clear flag of a row.
  function automatic fz_t first_zero(input row_t v);
    fz_t r;
    r.found = 1'b0;
    r.idx   = '0;
    for (int i = ROW_BITS - 1; i >= 0; i--) begin
      if (!v[i]) begin
        r.found = 1'b1;
        r.idx   = BIT_W'(i);
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[design/ust_bitmap.sv]
// Completion bitmap of the tracker: a row-organised memory with one valid bit per row.
// Depends on ust_pkg for the row geometry and the request struct.
`default_nettype none

module ust_bitmap
  import ust_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire bm_req_t req,
  output row_t         rd_data
);

  row_t            mem [ROWS];
  row_t            rd_q_r;
  logic [ROWS-1:0] row_valid_r;
  logic            rd_valid_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_row] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_q_r <= mem[req.rd_row];
    end
  end

  // A row never written since the last clear reads as all zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_valid_r <= '0;
      rd_valid_r  <= 1'b0;
    end else begin
      if (req.clear) begin
        row_valid_r <= '0;
      end else if (req.wr_en) begin
        row_valid_r[req.wr_row] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_valid_r <= row_valid_r[req.rd_row];
      end
    end
  end

  assign rd_data = rd_valid_r ? rd_q_r : '0;

endmodule

`default_nettype wire

[design/upload_slice_tracker_core.sv]
// Top level of the upload slice tracker: request sequencer, context registers, result register.
// Depends on ust_pkg and ust_bitmap.
//
//   channel | ports                                                  | direction
//   --------+--------------------------------------------------------+----------
//   in      | in_valid/in_ready, in_slice_number, in_data_length,    | request in
//           | in_write_ok                                            |
//   out     | out_valid/out_ready, out_next_slice, out_done_count,   | result out
//           | out_count_valid, out_upload_complete                   |
//   cfg     | cfg_valid/cfg_ready, cfg_file_size                     | write in
//
// Every request passes the check state. One that is rejected, meets an inactive tracker or
// reports a failed write goes on to emit; one that allocates a slice without completing one
// passes the allocation state first; one that completes a slice walks scan read, scan check
// and allocation; the lowest unfinished slice pointer advances one 32-bit row per cycle.
// The input is ready only in the idle state while no file size write is offered; a waiting
// result holds the sequencer in its emit state. Reset is synchronous and leaves the tracker
// inactive; writing the file size opens a new context and invalidates every bitmap row at once.
`default_nettype none

module upload_slice_tracker_core
  import ust_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire logic [SLICE_W-1:0] in_slice_number,
  input  wire logic [LEN_W-1:0]   in_data_length,
  input  wire logic               in_write_ok,
  output      logic               out_valid,
  input  wire logic               out_ready,
  output      logic [SLICE_W-1:0] out_next_slice,
  output      logic [SLICE_W-1:0] out_done_count,
  output      logic               out_count_valid,
  output      logic               out_upload_complete,
  input  wire logic               cfg_valid,
  output      logic               cfg_ready,
  input  wire logic [FSIZE_W-1:0] cfg_file_size
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_CHK,
    S_ALLOC,
    S_EMIT
  } state_t;

  state_t state_r;

  // Context
  logic               active_r;
  logic [SLICE_W-1:0] count_r;
  logic [LEN_W-1:0]   last_len_r;
  logic               fzero_r;
  logic [SLICE_W-1:0] low_r;
  logic [SLICE_W-1:0] hi_r;
  logic [SLICE_W-1:0] done_r;

  // Request being worked on
  logic [SLICE_W-1:0] num_r;
  logic [LEN_W-1:0]   len_r;
  logic               ok_r;
  logic [ROW_W-1:0]   scan_row_r;
  logic [BIT_W-1:0]   scan_off_r;

  // Pending result
  logic [SLICE_W-1:0] res_next_r;
  logic               res_valid_r;
  logic               res_comp_r;

  logic               out_valid_r;
  logic [SLICE_W-1:0] out_next_r;
  logic [SLICE_W-1:0] out_done_r;
  logic               out_cv_r;
  logic               out_comp_r;

  logic in_fire;
  logic cfg_fire;

  bm_req_t bm_req;
  row_t    bm_rdata;

  ust_bitmap u_bitmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (bm_req),
    .rd_data (bm_rdata)
  );

  // A file size write takes precedence, so a request never starts in the same cycle.
  assign in_ready  = (state_r == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state_r == S_IDLE);
  assign in_fire   = in_valid & in_ready;
  assign cfg_fire  = cfg_valid & cfg_ready;

  // Slice count rounded up and saturated, and expected length of the last slice.
  logic [FSIZE_W:0]   cfg_sum;
  logic [FSIZE_W:0]   cfg_ceil;
  logic [SLICE_W-1:0] cfg_count;
  logic [LEN_W-1:0]   cfg_last_len;

  always_comb begin
    cfg_sum  = {1'b0, cfg_file_size} + (FSIZE_W + 1)'(SLICE_BYTES - 1);
    cfg_ceil = cfg_sum >> SLICE_SHIFT;
    if (cfg_ceil > (FSIZE_W + 1)'(MAX_SLICES)) begin
      cfg_count = SLICE_W'(MAX_SLICES);
    end else begin
      cfg_count = cfg_ceil[SLICE_W-1:0];
    end
    if (cfg_file_size[SLICE_SHIFT-1:0] == '0) begin
      cfg_last_len = LEN_W'(SLICE_BYTES);
    end else begin
      cfg_last_len = LEN_W'(cfg_file_size[SLICE_SHIFT-1:0]);
    end
  end

  // Length check and bitmap addressing for the latched request.
  logic [SLICE_W-1:0] num_m1;
  logic [SLICE_W-1:0] in_m1;
  logic [SLICE_W-1:0] low_m1;
  logic               pass;
  logic               cur_bit;
  row_t               scan_word;
  fz_t                fz;
  logic [SLICE_W-1:0] found_slice;

  always_comb begin
    num_m1  = num_r - SLICE_W'(1);
    in_m1   = in_slice_number - SLICE_W'(1);
    low_m1  = low_r - SLICE_W'(1);
    pass    = ((num_r < count_r) && (len_r == LEN_W'(SLICE_BYTES))) ||
              ((num_r == count_r) && (len_r == last_len_r));
    cur_bit = bm_rdata[num_m1[BIT_W-1:0]];
    // Flags below the starting offset count as finished.
    scan_word   = bm_rdata | ~({ROW_BITS{1'b1}} << scan_off_r);
    fz          = first_zero(scan_word);
    found_slice = SLICE_W'({scan_row_r, fz.idx}) + SLICE_W'(1);
  end

  always_comb begin
    bm_req         = '0;
    bm_req.clear   = cfg_fire;
    bm_req.wr_row  = num_m1[IDX_W-1:BIT_W];
    bm_req.wr_data = bm_rdata | (row_t'(1) << num_m1[BIT_W-1:0]);
    unique case (state_r)
      S_IDLE: begin
        bm_req.rd_en  = in_fire;
        bm_req.rd_row = in_m1[IDX_W-1:BIT_W];
      end
      S_CHECK: begin
        bm_req.wr_en = active_r && (num_r != '0) && pass && !cur_bit && ok_r;
      end
      S_SCAN_RD: begin
        bm_req.rd_en  = 1'b1;
        bm_req.rd_row = low_m1[IDX_W-1:BIT_W];
      end
      S_SCAN_CHK: begin
        bm_req.rd_en  = !fz.found && (scan_row_r != ROW_W'(ROWS - 1));
        bm_req.rd_row = scan_row_r + ROW_W'(1);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= 1'b0;
      count_r     <= '0;
      last_len_r  <= LEN_W'(SLICE_BYTES);
      fzero_r     <= 1'b1;
      low_r       <= SLICE_W'(1);
      hi_r        <= '0;
      done_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // The emit state always leaves a result in the output register.
      if (out_valid_r && out_ready && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_fire) begin
        active_r   <= 1'b1;
        count_r    <= cfg_count;
        last_len_r <= cfg_last_len;
        fzero_r    <= (cfg_file_size == '0);
        low_r      <= SLICE_W'(1);
        hi_r       <= '0;
        done_r     <= '0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            num_r       <= in_slice_number;
            len_r       <= in_data_length;
            ok_r        <= in_write_ok;
            res_valid_r <= 1'b0;
            res_comp_r  <= 1'b0;
            state_r     <= S_CHECK;
          end
        end
        S_CHECK: begin
          priority if (!active_r) begin
            res_next_r <= '0;
            state_r    <= S_EMIT;
          end else if ((num_r != '0) && !pass) begin
            res_next_r <= low_r;
            state_r    <= S_EMIT;
          end else if ((num_r != '0) && !cur_bit) begin
            if (!ok_r) begin
              res_next_r <= num_r;
              state_r    <= S_EMIT;
            end else begin
              done_r      <= done_r + SLICE_W'(1);
              res_valid_r <= 1'b1;
              state_r     <= S_SCAN_RD;
            end
          end else begin
            state_r <= S_ALLOC;
          end
        end
        S_SCAN_RD: begin
          scan_row_r <= low_m1[IDX_W-1:BIT_W];
          scan_off_r <= low_m1[BIT_W-1:0];
          state_r    <= S_SCAN_CHK;
        end
        S_SCAN_CHK: begin
          priority if (fz.found) begin
            low_r   <= found_slice;
            state_r <= S_ALLOC;
          end else if (scan_row_r == ROW_W'(ROWS - 1)) begin
            low_r   <= SLICE_W'(MAX_SLICES + 1);
            state_r <= S_ALLOC;
          end else begin
            scan_row_r <= scan_row_r + ROW_W'(1);
            scan_off_r <= '0;
          end
        end
        S_ALLOC: begin
          if (hi_r < count_r) begin
            hi_r <= hi_r + SLICE_W'(1);
          end
          // All slices finished, or an empty file: the context closes.
          priority if ((low_r > count_r) || fzero_r) begin
            active_r   <= 1'b0;
            res_next_r <= '0;
            res_comp_r <= 1'b1;
          end else if (hi_r < count_r) begin
            res_next_r <= hi_r + SLICE_W'(1);
          end else begin
            res_next_r <= low_r;
          end
          state_r <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_next_r  <= res_next_r;
            out_done_r  <= done_r;
            out_cv_r    <= res_valid_r;
            out_comp_r  <= res_comp_r;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid           = out_valid_r;
  assign out_next_slice      = out_next_r;
  assign out_done_count      = out_done_r;
  assign out_count_valid     = out_cv_r;
  assign out_upload_complete = out_comp_r;

endmodule

`default_nettype wire

[dv/upload_slice_tracker_core_test.sv]
// Self-checking testbench for upload_slice_tracker_core: directed and random slice reports
// against an internal tracker model, with random sender gaps and receiver stalls.
// Depends on ust_pkg and the upload_slice_tracker_core RTL.
`timescale 1ns / 1ps

module upload_slice_tracker_core_test;
  import ust_pkg::*;

  localparam int ITEM_TARGET = 1450;

  typedef struct packed {
    logic [SLICE_W-1:0] next_slice;
    logic [SLICE_W-1:0] done_count;
    logic               count_valid;
    logic               upload_complete;
  } tracker_result_t;

  typedef enum int {RPT_HINTED, RPT_ASK, RPT_ANY_SLICE, RPT_BAD_LENGTH, RPT_WILD} report_kind_t;
  typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [SLICE_W-1:0] in_slice_number = '0;
  logic [LEN_W-1:0]   in_data_length = '0;
  logic               in_write_ok = 1'b0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [SLICE_W-1:0] out_next_slice;
  logic [SLICE_W-1:0] out_done_count;
  logic               out_count_valid;
  logic               out_upload_complete;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [FSIZE_W-1:0] cfg_file_size = '0;

  upload_slice_tracker_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_slice_number     (in_slice_number),
    .in_data_length      (in_data_length),
    .in_write_ok         (in_write_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_next_slice      (out_next_slice),
    .out_done_count      (out_done_count),
    .out_count_valid     (out_count_valid),
    .out_upload_complete (out_upload_complete),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_file_size       (cfg_file_size)
  );

  always #5 clk = ~clk;

  // Tracker model state, as it stands after reset.
  bit                 slice_done [0:MAX_SLICES];
  int unsigned        lowest_open = 1;
  int unsigned        highest_issued = 0;
  int unsigned        slices_done = 0;
  int unsigned        slice_total = 0;
  int unsigned        last_slice_bytes = SLICE_BYTES;
  longint unsigned    file_bytes = 0;
  bit                 tracking = 1'b0;

  tracker_result_t    pending_answers [$];
  logic [SLICE_W-1:0] last_hint = '0;
  int unsigned        requests_sent = 0;
  int unsigned        mismatches = 0;
  int unsigned        burst_left = 0;

  rx_mode_t           rx_mode = RX_OPEN;
  int unsigned        rx_left = 0;
  int unsigned        rx_tick = 0;

  function automatic void open_context(input logic [FSIZE_W-1:0] fs);
    longint unsigned n;
    file_bytes = fs;
    n = (file_bytes + SLICE_BYTES - 1) / SLICE_BYTES;
    slice_total = (n > MAX_SLICES) ? MAX_SLICES : int'(n);
    last_slice_bytes = int'(file_bytes % SLICE_BYTES);
    if (last_slice_bytes == 0) last_slice_bytes = SLICE_BYTES;
    foreach (slice_done[i]) slice_done[i] = 1'b0;
    lowest_open = 1;
    highest_issued = 0;
    slices_done = 0;
    tracking = 1'b1;
    last_hint = '0;
  endfunction

  // Works out the answer to one slice report and advances the model.
  function automatic tracker_result_t track_report(input logic [SLICE_W-1:0] num,
                                                   input logic [LEN_W-1:0] len,
                                                   input logic ok);
    tracker_result_t    r;
    logic [SLICE_W-1:0] hint;
    bit                 pass;
    r.next_slice      = '0;
    r.done_count      = SLICE_W'(slices_done);
    r.count_valid     = 1'b0;
    r.upload_complete = 1'b0;
    if (!tracking) return r;
    if (num != 0) begin
      pass = (num < slice_total && len == SLICE_BYTES) ||
             (num == slice_total && len == last_slice_bytes);
      if (!pass) begin
        r.next_slice = SLICE_W'(lowest_open);
        return r;
      end
      if (!slice_done[num]) begin
        if (!ok) begin
          r.next_slice = num;
          return r;
        end
        slice_done[num] = 1'b1;
        while (lowest_open <= MAX_SLICES && slice_done[lowest_open]) lowest_open++;
        slices_done++;
        r.count_valid = 1'b1;
      end
    end
    // Fresh slices are handed out before any retry of an unfinished one.
    if (highest_issued < slice_total) begin
      highest_issued++;
      hint = SLICE_W'(highest_issued);
    end else begin
      hint = SLICE_W'(lowest_open);
    end
    r.done_count = SLICE_W'(slices_done);
    if (lowest_open > slice_total || file_bytes == 0) begin
      tracking = 1'b0;
      r.upload_complete = 1'b1;
      return r;
    end
    r.next_slice = hint;
    return r;
  endfunction

  function automatic logic [LEN_W-1:0] slice_length(input int unsigned num);
    return (num == slice_total) ? LEN_W'(last_slice_bytes) : LEN_W'(SLICE_BYTES);
  endfunction

  // Called just after a falling edge; returns at a falling edge with the request accepted.
  task automatic send_report(input logic [SLICE_W-1:0] num, input logic [LEN_W-1:0] len,
                             input logic ok);
    tracker_result_t r;
    int unsigned     gap;
    in_valid        <= 1'b1;
    in_slice_number <= num;
    in_data_length  <= len;
    in_write_ok     <= ok;
    do @(posedge clk); while (!in_ready);
    r = track_report(num, len, ok);
    pending_answers = {pending_answers, r};
    last_hint = r.next_slice;
    requests_sent++;
    @(negedge clk);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  task automatic write_file_size(input logic [FSIZE_W-1:0] fs);
    drain_results();
    cfg_valid     <= 1'b1;
    cfg_file_size <= fs;
    do @(posedge clk); while (!cfg_ready);
    open_context(fs);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random_report();
    report_kind_t       kind;
    int unsigned        pick;
    int unsigned        top;
    logic [SLICE_W-1:0] num;
    logic [LEN_W-1:0]   len;
    logic               ok;
    pick = $urandom_range(0, 99);
    kind = (pick < 72) ? RPT_HINTED : (pick < 78) ? RPT_ASK : (pick < 88) ? RPT_ANY_SLICE :
           (pick < 95) ? RPT_BAD_LENGTH : RPT_WILD;
    top  = (slice_total == 0) ? 1 : slice_total;
    num  = last_hint;
    len  = slice_length(last_hint);
    ok   = ($urandom_range(0, 9) != 0);
    unique case (kind)
      RPT_HINTED: begin
        if (last_hint == 0) len = LEN_W'($urandom);
      end
      RPT_ASK: begin
        num = '0;
        len = LEN_W'($urandom);
        ok  = 1'($urandom);
      end
      RPT_ANY_SLICE: begin
        // Reports slices out of order, finished ones included.
        num = SLICE_W'($urandom_range(1, top));
        len = slice_length(num);
        ok  = ($urandom_range(0, 4) != 0);
      end
      RPT_BAD_LENGTH: begin
        if ($urandom_range(0, 1) != 0) num = SLICE_W'($urandom_range(1, top));
        len = slice_length(num) ^ (LEN_W'(1) << $urandom_range(0, LEN_W - 1));
      end
      default: begin
        num = SLICE_W'($urandom);
        len = LEN_W'($urandom);
        ok  = 1'($urandom);
      end
    endcase
    if ($urandom_range(0, 59) == 0) drain_results();
    send_report(num, len, ok);
  endtask

  task automatic test_idle_tracker();
    send_report('0, '0, 1'b0);
    send_report(SLICE_W'(1), LEN_W'(SLICE_BYTES), 1'b1);
    send_report('1, '1, 1'b1);
    send_report(SLICE_W'(MAX_SLICES), LEN_W'(SLICE_BYTES), 1'b0);
  endtask

  // Four slices, the last one holding 100 bytes.
  task automatic test_partial_last_slice();
    write_file_size(FSIZE_W'(3 * SLICE_BYTES + 100));
    send_report('0, '0, 1'b1);
    send_report(SLICE_W'(1), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(4), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(4), LEN_W'(100), 1'b0);
    send_report(SLICE_W'(5), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(1), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(2), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(4), LEN_W'(100), 1'b1);
    send_report(SLICE_W'(3), LEN_W'(SLICE_BYTES), 1'b1);
    send_report(SLICE_W'(1), LEN_W'(SLICE_BYTES), 1'b1);
  endtask

  task automatic test_empty_file();
    write_file_size('0);
    send_report(SLICE_W'(1), '0, 1'b1);
    send_report('0, '1, 1'b0);
    send_report('0, '0, 1'b1);
  endtask

  // Oversized and full-size files saturate the slice count; a one-byte file closes after its one slice.
  task automatic test_largest_files();
    write_file_size('1);
    send_report(SLICE_W'(MAX_SLICES), LEN_W'(SLICE_BYTES - 1), 1'b1);
    send_report(SLICE_W'(MAX_SLICES + 1), LEN_W'(SLICE_BYTES), 1'b1);
    send_report('1, '1, 1'b1);
    write_file_size(FSIZE_W'(MAX_SLICES * SLICE_BYTES));
    send_report(SLICE_W'(MAX_SLICES), LEN_W'(SLICE_BYTES), 1'b0);
    send_report(SLICE_W'(1), LEN_W'(SLICE_BYTES), 1'b1);
    write_file_size(FSIZE_W'(1));
    send_report('0, '0, 1'b0);
    send_report(SLICE_W'(1), LEN_W'(1), 1'b1);
  endtask

  task automatic test_random_uploads();
    int unsigned        pick;
    int unsigned        n;
    int unsigned        budget;
    int unsigned        k;
    logic [FSIZE_W-1:0] fs;
    while (requests_sent < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      n    = $urandom_range(1, 40);
      if (pick < 68)
        fs = FSIZE_W'((n - 1) * SLICE_BYTES + $urandom_range(1, SLICE_BYTES));
      else if (pick < 80)
        fs = FSIZE_W'(n * SLICE_BYTES);
      else if (pick < 87)
        fs = ($urandom_range(0, 3) == 0) ? '0 : FSIZE_W'($urandom_range(1, SLICE_BYTES));
      else if (pick < 97)
        fs = FSIZE_W'($urandom_range((MAX_SLICES - 1) * SLICE_BYTES, 32'h7FFF_FFFF));
      else
        fs = FSIZE_W'($urandom_range(64, 200) * SLICE_BYTES - $urandom_range(0, SLICE_BYTES - 1));
      write_file_size(fs);
      // Huge contexts get a short look only; the rest are given room to finish.
      budget = (slice_total > 200) ? 40 : 2 * slice_total + 12;
      for (k = 0; k < budget && tracking && requests_sent < ITEM_TARGET; k++)
        send_random_report();
      repeat ($urandom_range(0, 2)) send_random_report();
    end
  endtask

  task automatic check_field(input string field, input logic [SLICE_W-1:0] want,
                             input logic [SLICE_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: %s expected %0d, got %0d", $realtime, field, want, got);
    end
  endtask

  always @(posedge clk) begin : answer_check
    tracker_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no request outstanding, next_slice %0d", $realtime,
                   out_next_slice);
      end else begin
        want = pending_answers.pop_front();
        check_field("next_slice", want.next_slice, out_next_slice);
        check_field("done_count", want.done_count, out_done_count);
        check_field("count_valid", SLICE_W'(want.count_valid), SLICE_W'(out_count_valid));
        check_field("upload_complete", SLICE_W'(want.upload_complete),
                    SLICE_W'(out_upload_complete));
      end
    end
  end

  // The receiver changes its stall behaviour every so often.
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= rx_mode_t'($urandom_range(0, 3));
      rx_left <= $urandom_range(20, 200);
    end else begin
      rx_left <= rx_left - 1;
    end
    rx_tick <= rx_tick + 1;
    unique case (rx_mode)
      RX_OPEN:   out_ready <= 1'b1;
      RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
      RX_SPARSE: out_ready <= ($urandom_range(0, 5) == 0);
      default:   out_ready <= ((rx_tick % 7) < 3);
    endcase
  end

  initial begin
    #10_000_000;
    $display("upload_slice_tracker_core_test: FAIL");
    $finish;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_idle_tracker();
    test_partial_last_slice();
    test_empty_file();
    test_largest_files();
    test_random_uploads();
    drain_results();
    repeat (50) @(negedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("upload_slice_tracker_core_test: PASS");
    end else begin
      $display("upload_slice_tracker_core_test: FAIL");
    end
    $finish;
  end

endmodule

[upload_slice_tracker_core.f]
design/ust_pkg.sv
design/ust_bitmap.sv
design/upload_slice_tracker_core.sv
dv/upload_slice_tracker_core_test.sv
